// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and widths of the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned RadW  = 34;
  localparam int unsigned SqrtW = RadW / 2;
  localparam int unsigned NumW  = 35;
  localparam int unsigned DenW  = 17;
  localparam int unsigned QuotW = 34;
  localparam int unsigned FracW = 16;

  typedef enum logic [2:0] {
    CODE_ALL_X  = 3'd0,
    CODE_NONE   = 3'd1,
    CODE_LINEAR = 3'd2,
    CODE_NEG    = 3'd3,
    CODE_DOUBLE = 3'd4,
    CODE_TWO    = 3'd5
  } code_e;

  typedef struct packed {
    code_e                    code;
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic signed [CoefW-1:0]  c;
  } side_t;

endpackage

// ===== design/quadratic_root_solver_unit.sv =====
// Throughput: one coefficient set per cycle; the whole pipeline advances
// together and holds while the output register is full and not taken.
// The depth is set by the 17-stage square root and the 36-stage dividers.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Solves a*x^2 + b*x + c = 0 in fixed point and returns a case code and roots.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit
  import qrs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoefW-1:0]  coef_a_i,
  input  logic signed [CoefW-1:0]  coef_b_i,
  input  logic signed [CoefW-1:0]  coef_c_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               case_code_o,
  output logic signed [QuotW-1:0]  root_first_o,
  output logic signed [QuotW-1:0]  root_second_o
);

  logic en;

  logic                    s1_v_q;
  logic signed [CoefW-1:0] s1_a_q, s1_b_q, s1_c_q;

  logic                      s2_v_q;
  logic signed [2*CoefW-1:0] s2_bb_q, s2_ac_q;
  logic signed [CoefW-1:0]   s2_a_q, s2_b_q, s2_c_q;

  logic signed [RadW-1:0] disc;
  code_e                  code_d;

  logic            s3_v_q;
  logic [RadW-1:0] s3_rad_q;
  side_t           s3_side_q;

  logic             sq_v;
  logic [SqrtW-1:0] sq_root;
  side_t            sq_side;

  logic signed [SqrtW:0]   neg_b;
  logic signed [SqrtW:0]   sum_p, sum_m;
  logic signed [NumW-1:0]  num1_d, num2_d;
  logic signed [DenW-1:0]  den_d;

  logic                   s4_v_q;
  logic signed [NumW-1:0] s4_num1_q, s4_num2_q;
  logic signed [DenW-1:0] s4_den_q;
  code_e                  s4_code_q;

  logic                    d1_v, d2_v;
  logic signed [QuotW-1:0] d1_q, d2_q;
  code_e                   d1_code, d2_code;

  assign en         = ~d1_v | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= sq_v;
    end
  end

  always_comb begin
    disc = RadW'(s2_bb_q) - (RadW'(s2_ac_q) <<< 2);
    if (s2_a_q == '0) begin
      if (s2_b_q == '0) begin
        code_d = (s2_c_q == '0) ? CODE_ALL_X : CODE_NONE;
      end else begin
        code_d = CODE_LINEAR;
      end
    end else if (disc < 0) begin
      code_d = CODE_NEG;
    end else if (disc == '0) begin
      code_d = CODE_DOUBLE;
    end else begin
      code_d = CODE_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q <= coef_a_i;
      s1_b_q <= coef_b_i;
      s1_c_q <= coef_c_i;
      s2_bb_q <= s1_b_q * s1_b_q;
      s2_ac_q <= s1_a_q * s1_c_q;
      s2_a_q  <= s1_a_q;
      s2_b_q  <= s1_b_q;
      s2_c_q  <= s1_c_q;
      s3_rad_q       <= disc[RadW-1] ? '0 : disc;
      s3_side_q.code <= code_d;
      s3_side_q.a    <= s2_a_q;
      s3_side_q.b    <= s2_b_q;
      s3_side_q.c    <= s2_c_q;
    end
  end

  qrs_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  always_comb begin
    neg_b  = -(SqrtW+1)'(sq_side.b);
    sum_p  = neg_b + $signed({1'b0, sq_root});
    sum_m  = neg_b - $signed({1'b0, sq_root});
    num1_d = '0;
    num2_d = '0;
    den_d  = DenW'(1);
    case (sq_side.code)
      CODE_LINEAR: begin
        num1_d = NumW'(-(CoefW+1)'(sq_side.c)) <<< FracW;
        den_d  = DenW'(sq_side.b);
      end
      CODE_DOUBLE: begin
        num1_d = NumW'(neg_b) <<< FracW;
        den_d  = {sq_side.a, 1'b0};
      end
      CODE_TWO: begin
        num1_d = NumW'(sum_p) <<< FracW;
        num2_d = NumW'(sum_m) <<< FracW;
        den_d  = {sq_side.a, 1'b0};
      end
      default: begin
        num1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_num1_q <= num1_d;
      s4_num2_q <= num2_d;
      s4_den_q  <= den_d;
      s4_code_q <= sq_side.code;
    end
  end

  qrs_div_pipe u_div_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_i   (s4_num1_q),
    .den_i   (s4_den_q),
    .code_i  (s4_code_q),
    .valid_o (d1_v),
    .quot_o  (d1_q),
    .code_o  (d1_code)
  );

  qrs_div_pipe u_div_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_i   (s4_num2_q),
    .den_i   (s4_den_q),
    .code_i  (s4_code_q),
    .valid_o (d2_v),
    .quot_o  (d2_q),
    .code_o  (d2_code)
  );

  assign out_valid_o   = d1_v;
  assign case_code_o   = d1_code;
  assign root_first_o  = d1_q;
  assign root_second_o = d2_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d1_v == d2_v) && (!d1_v || d1_code == d2_code))
    else $error("root dividers out of step");

  a_second_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && d1_code != CODE_TWO) |-> (root_second_o == '0))
    else $error("second root nonzero when unused");

  a_first_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (d1_code == CODE_ALL_X || d1_code == CODE_NONE ||
                     d1_code == CODE_NEG)) |-> (root_first_o == '0))
    else $error("first root nonzero when unused");

endmodule

// ===== design/qrs_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Floor square root, one result bit per pipeline stage, with sideband.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe
  import qrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RadW-1:0]   rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [SqrtW-1:0]  root_o,
  output side_t             side_o
);

  localparam int unsigned RemW = SqrtW + 3;

  logic              v_q    [SqrtW];
  logic [RadW-1:0]   rad_q  [SqrtW];
  logic [RemW-1:0]   rem_q  [SqrtW];
  logic [SqrtW-1:0]  root_q [SqrtW];
  side_t             side_q [SqrtW];

  for (genvar i = 0; i < SqrtW; i++) begin : g_stage
    logic              v_s;
    logic [RadW-1:0]   rad_s;
    logic [RemW-1:0]   rem_s;
    logic [SqrtW-1:0]  root_s;
    side_t             side_s;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic              ge;
    logic [RemW-1:0]   rem_d;
    logic [SqrtW-1:0]  root_d;

    if (i == 0) begin : g_src_in
      assign v_s    = valid_i;
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign side_s = side_i;
    end else begin : g_src_prev
      assign v_s    = v_q[i-1];
      assign rad_s  = rad_q[i-1];
      assign rem_s  = rem_q[i-1];
      assign root_s = root_q[i-1];
      assign side_s = side_q[i-1];
    end

    assign rem_sh = {rem_s[RemW-3:0], rad_s[RadW-1 -: 2]};
    assign trial  = {1'b0, root_s, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;
    assign root_d = {root_s[SqrtW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_s[RadW-3:0], 2'b00};
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        side_q[i] <= side_s;
      end
    end
  end

  assign valid_o = v_q[SqrtW-1];
  assign root_o  = root_q[SqrtW-1];
  assign side_o  = side_q[SqrtW-1];

endmodule

// ===== design/qrs_div_pipe.sv =====
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Signed division truncating toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe
  import qrs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [NumW-1:0]  num_i,
  input  logic signed [DenW-1:0]  den_i,
  input  code_e                   code_i,
  output logic                    valid_o,
  output logic signed [QuotW-1:0] quot_o,
  output code_e                   code_o
);

  logic [NumW-1:0]  num_abs;
  logic [DenW-1:0]  den_abs;

  logic             ent_v_q;
  logic [QuotW-1:0] ent_n_q;
  logic [DenW-1:0]  ent_d_q;
  logic             ent_neg_q;
  code_e            ent_code_q;

  logic             v_q    [QuotW];
  logic [QuotW-1:0] n_q    [QuotW];
  logic [DenW-1:0]  d_q    [QuotW];
  logic [DenW-1:0]  rem_q  [QuotW];
  logic [QuotW-1:0] q_q    [QuotW];
  logic             neg_q  [QuotW];
  code_e            code_q [QuotW];

  logic                    out_v_q;
  logic signed [QuotW-1:0] out_quot_q;
  code_e                   out_code_q;

  assign num_abs = num_i[NumW-1] ? (-num_i) : num_i;
  assign den_abs = den_i[DenW-1] ? (-den_i) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_n_q    <= num_abs[QuotW-1:0];
      ent_d_q    <= den_abs;
      ent_neg_q  <= num_i[NumW-1] ^ den_i[DenW-1];
      ent_code_q <= code_i;
    end
  end

  for (genvar i = 0; i < QuotW; i++) begin : g_stage
    logic             v_s;
    logic [QuotW-1:0] n_s;
    logic [DenW-1:0]  d_s;
    logic [DenW-1:0]  rem_s;
    logic [QuotW-1:0] q_s;
    logic             neg_s;
    code_e            code_s;
    logic [DenW:0]    rem_sh;
    logic             ge;
    logic [DenW:0]    rem_sub;

    if (i == 0) begin : g_src_in
      assign v_s    = ent_v_q;
      assign n_s    = ent_n_q;
      assign d_s    = ent_d_q;
      assign rem_s  = '0;
      assign q_s    = '0;
      assign neg_s  = ent_neg_q;
      assign code_s = ent_code_q;
    end else begin : g_src_prev
      assign v_s    = v_q[i-1];
      assign n_s    = n_q[i-1];
      assign d_s    = d_q[i-1];
      assign rem_s  = rem_q[i-1];
      assign q_s    = q_q[i-1];
      assign neg_s  = neg_q[i-1];
      assign code_s = code_q[i-1];
    end

    assign rem_sh  = {rem_s, n_s[QuotW-1]};
    assign ge      = (rem_sh >= {1'b0, d_s});
    assign rem_sub = ge ? (rem_sh - {1'b0, d_s}) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i]    <= {n_s[QuotW-2:0], 1'b0};
        d_q[i]    <= d_s;
        rem_q[i]  <= rem_sub[DenW-1:0];
        q_q[i]    <= {q_s[QuotW-2:0], ge};
        neg_q[i]  <= neg_s;
        code_q[i] <= code_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[QuotW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_quot_q <= neg_q[QuotW-1] ? $signed(-q_q[QuotW-1]) : $signed(q_q[QuotW-1]);
      out_code_q <= code_q[QuotW-1];
    end
  end

  assign valid_o = out_v_q;
  assign quot_o  = out_quot_q;
  assign code_o  = out_code_q;

endmodule
